// File: hw/rtl/lruc_pkg.sv
// Shared constants and types for the LRU cache unit.
// Used by lruc_cell and lru_cache_exact_key_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lruc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 32;

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	// fixed port widths
	localparam int CAP_W     = 5;
	localparam int KEY_W     = 64;
	localparam int VALUE_W   = 32;
	localparam int OCC_W     = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// broadcast from the control logic to every cell
	typedef struct packed {
		logic                  load;        // item accepted: compare lookup_key
		logic [KEY_BITS-1:0]   lookup_key;
		logic                  exec;        // update cycle
		logic                  put;
		logic                  hit;
		logic [RANK_W-1:0]     hit_rank;
		logic                  do_insert;
		logic                  do_evict;
		logic [RANK_W-1:0]     oldest_rank;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} lruc_cmd_t;

	// state that each cell reports back
	typedef struct packed {
		logic              match;
		logic              valid;
		logic [RANK_W-1:0] rank;
	} lruc_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lruc_cell.sv
// One cache slot: key, payload, valid bit and recency rank.
// Depends on lruc_pkg; chained through a free-slot token to its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module lruc_cell
	import lruc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lruc_cmd_t             cmd,
	input  wire logic                  free_in,
	output logic                       free_out,
	output lruc_stat_t                 stat,
	output logic [VALUE_BITS-1:0]      payload
);

	logic                  valid_q;
	logic                  match_q;
	logic [RANK_W-1:0]     rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] payload_q;

	logic target_free;
	logic target_evict;
	logic target;

	// lowest-index free slot: no free cell seen earlier in the chain
	assign free_out     = free_in | ~valid_q;
	assign target_free  = cmd.do_insert & ~cmd.do_evict & ~valid_q & ~free_in;
	assign target_evict = cmd.do_insert & cmd.do_evict & valid_q &
		(rank_q == cmd.oldest_rank);
	assign target       = target_free | target_evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.load) begin
			match_q <= valid_q & (key_q == cmd.lookup_key);
		end else if (cmd.exec) begin
			priority if (match_q) begin
				rank_q <= '0;
			end else if (target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else begin
				// age entries younger than the touched one, or all on insert
				if (valid_q && (cmd.hit ? (rank_q < cmd.hit_rank) : cmd.do_insert))
					rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (match_q && cmd.put) begin
				payload_q <= cmd.value;
			end else if (!match_q && target) begin
				key_q     <= cmd.key;
				payload_q <= cmd.value;
			end
		end
	end

	assign stat.match = match_q;
	assign stat.valid = valid_q;
	assign stat.rank  = rank_q;
	assign payload    = payload_q;

endmodule

`default_nettype wire

// File: hw/rtl/lru_cache_exact_key_unit.sv
// Top level of the fully associative LRU cache: control, chain of slot cells,
// result register. Depends on lruc_pkg and lruc_cell.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache of ENTRIES slots with least-recently-used
// replacement and exact key match. At the accept edge every cell compares
// its stored key with key_word in parallel; then, in the update cycle, all
// cells update their ranks, payload and valid bits at once and the result
// is loaded into the output register. in_stall is high from the accept until
// that update cycle is done, so the unit takes no new item while one is in
// flight; a stalled output register holds the update cycle until the result
// slot frees. capacity may be written only while the unit is idle.
module lru_cache_exact_key_unit
	import lruc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CAP_W-1:0]   cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [KEY_W-1:0]   key_word,
	input  wire logic [VALUE_W-1:0] value_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output logic [VALUE_W-1:0]      value_out,
	output logic                    evicted,
	output logic [OCC_W-1:0]        occupancy
);

	logic [CAP_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  busy_q;
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_W-1:0]    value_out_q;
	logic                  evicted_q;
	logic [OCC_W-1:0]      occupancy_q;

	logic                  accept;
	logic                  exec;
	logic [CNT_W-1:0]      cap_eff;
	logic [CNT_W-1:0]      fill_next;
	logic [CNT_W-1:0]      fill_m1;
	logic                  any_hit;
	logic [RANK_W-1:0]     hit_rank;
	logic [VALUE_BITS-1:0] hit_payload;
	logic                  do_insert;
	logic                  do_evict;

	lruc_cmd_t             cmd;
	lruc_stat_t            stat   [ENTRIES];
	logic [VALUE_BITS-1:0] pay    [ENTRIES];
	logic [ENTRIES:0]      free_chain;
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    valid_vec;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = busy_q;
	// hold the update cycle while the result register is full and stalled
	assign exec     = busy_q & (~out_valid_q | ~out_stall);

	assign cap_eff  = (int'(capacity_q) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(capacity_q);
	assign fill_m1  = fill_q - 1'b1;

	always_comb begin
		any_hit     = 1'b0;
		hit_rank    = '0;
		hit_payload = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = stat[i].match;
			valid_vec[i] = stat[i].valid;
			if (stat[i].match) begin
				any_hit     = 1'b1;
				hit_rank    = hit_rank | stat[i].rank;
				hit_payload = hit_payload | pay[i];
			end
		end
	end

	assign do_insert = ~any_hit & (op_q == OP_PUT) & (cap_eff != '0);
	assign do_evict  = do_insert & (fill_q >= cap_eff);
	assign fill_next = (do_insert & ~do_evict) ? fill_q + 1'b1 : fill_q;

	always_comb begin
		cmd.load        = accept;
		cmd.lookup_key  = key_word[KEY_BITS-1:0];
		cmd.exec        = exec;
		cmd.put         = (op_q == OP_PUT);
		cmd.hit         = any_hit;
		cmd.hit_rank    = hit_rank;
		cmd.do_insert   = do_insert;
		cmd.do_evict    = do_evict;
		cmd.oldest_rank = fill_m1[RANK_W-1:0];
		cmd.key         = key_q;
		cmd.value       = value_q;
	end

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lruc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.free_in  (free_chain[g]),
			.free_out (free_chain[g+1]),
			.stat     (stat[g]),
			.payload  (pay[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(16);
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (exec)
				busy_q <= 1'b0;
			if (exec)
				fill_q <= fill_next;
			if (exec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key_word[KEY_BITS-1:0];
			value_q <= value_word[VALUE_BITS-1:0];
		end
		if (exec) begin
			hit_q       <= any_hit;
			value_out_q <= (op_q == OP_GET) ? VALUE_W'(hit_payload) : '0;
			evicted_q   <= do_evict;
			occupancy_q <= OCC_W'(fill_next);
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = value_out_q;
	assign evicted   = evicted_q;
	assign occupancy = occupancy_q;

`ifndef SYNTHESIS
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match_vec))
		else $error("more than one cell matches the key");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(fill_q))
		else $error("fill count disagrees with valid cells");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= ENTRIES)
		else $error("fill count above slot count");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !out_valid_q) |=> (!busy_q && out_valid_q))
		else $error("update cycle did not complete");
`endif

endmodule

`default_nettype wire
